// ===== hw/rtl/rfbp_pkg.sv =====
// Shared types and constants for the ranging frame byte parser.
// No dependencies; the assembler and the top level use this package.
package rfbp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAME_LEN = 8;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] FIRST_POS = '0;

  // Frame kind byte expected at position 1.
  localparam logic [BYTE_W-1:0] KIND_BYTE = 8'h05;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = BYTE_W;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_VALUE = 1'b0,
    REG_TAIL_VALUE = 1'b1
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'd170;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'd85;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WAIT        = 3'd1,
    ST_LEN_ERR     = 3'd2,
    ST_OVF_ERR     = 3'd3,
    ST_CONTENT_ERR = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] sender_addr;
    logic [15:0] distance_cm;
    logic [7:0]  rssi_raw;
  } result_t;

endpackage

// ===== hw/rtl/rfbp_if.sv =====
// Stream channel interfaces for the ranging frame byte parser.
// Depends on nothing; valid/ready handshake with source and sink modports.
interface rfbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] sender_addr;
  logic [15:0] distance_cm;
  logic [7:0]  rssi_raw;

  modport source (output valid, output status, output sender_addr,
                  output distance_cm, output rssi_raw, input ready);
  modport sink   (input valid, input status, input sender_addr,
                  input distance_cm, input rssi_raw, output ready);
endinterface

// ===== hw/rtl/rfbp_assembler.sv =====
// Frame assembly state and per-byte decision logic.
// Depends on rfbp_pkg: holds the byte position and the stored frame bytes.
module rfbp_assembler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [rfbp_pkg::BYTE_W-1:0] rx_byte,
  input  logic [rfbp_pkg::BYTE_W-1:0] head_value,
  input  logic [rfbp_pkg::BYTE_W-1:0] tail_value,
  output rfbp_pkg::result_t           res
);

  logic [rfbp_pkg::POS_W-1:0]  pos_r;
  logic [rfbp_pkg::POS_W-1:0]  pos_nxt;
  // Byte 7 is never stored: on completion it equals the tail by definition.
  logic [rfbp_pkg::BYTE_W-1:0] frame_r [rfbp_pkg::FRAME_LEN-1];
  logic                        wr_en;
  logic [rfbp_pkg::POS_W-1:0]  wr_pos;
  logic                        is_head;
  logic                        is_tail;
  logic                        frame_good;

  assign is_head    = (rx_byte == head_value);
  assign is_tail    = (rx_byte == tail_value);
  assign frame_good = (frame_r[0] == head_value) && (frame_r[1] == rfbp_pkg::KIND_BYTE);

  always_comb begin
    pos_nxt = pos_r;
    wr_en   = 1'b0;
    wr_pos  = pos_r;
    res     = '{status: rfbp_pkg::ST_WAIT, sender_addr: '0, distance_cm: '0, rssi_raw: '0};
    priority if (is_head) begin
      wr_en   = 1'b1;
      wr_pos  = rfbp_pkg::FIRST_POS;
      pos_nxt = rfbp_pkg::POS_W'(1);
    end else if (is_tail) begin
      pos_nxt = rfbp_pkg::FIRST_POS;
      if (pos_r == rfbp_pkg::LAST_POS) begin
        if (frame_good) begin
          res.status      = rfbp_pkg::ST_OK;
          res.sender_addr = {frame_r[3], frame_r[2]};
          res.distance_cm = {frame_r[5], frame_r[4]};
          res.rssi_raw    = frame_r[6];
        end else begin
          res.status = rfbp_pkg::ST_CONTENT_ERR;
        end
      end else begin
        res.status = rfbp_pkg::ST_LEN_ERR;
      end
    end else if (pos_r != rfbp_pkg::LAST_POS) begin
      wr_en   = 1'b1;
      pos_nxt = pos_r + rfbp_pkg::POS_W'(1);
    end else begin
      pos_nxt    = rfbp_pkg::FIRST_POS;
      res.status = rfbp_pkg::ST_OVF_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= rfbp_pkg::FIRST_POS;
    end else if (adv) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      frame_r[wr_pos] <= rx_byte;
    end
  end

  // A finished or failed frame always rewinds the position.
  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (res.status != rfbp_pkg::ST_WAIT) |=> pos_r == rfbp_pkg::FIRST_POS)
    else $error("position not rewound after a frame result");

  // A good frame can only complete at the last position.
  a_ok_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (res.status == rfbp_pkg::ST_OK) |-> pos_r == rfbp_pkg::LAST_POS)
    else $error("frame reported complete before the last position");

  // A head byte always restarts at position one.
  a_head_restart: assert property (@(posedge clk) disable iff (!rst_n)
    adv && is_head |=> pos_r == rfbp_pkg::POS_W'(1))
    else $error("head byte did not restart the frame");

endmodule

// ===== hw/rtl/ranging_frame_byte_parser.sv =====
// Top level of the ranging frame byte parser.
// Depends on rfbp_pkg, rfbp_in_if/rfbp_out_if and rfbp_assembler.
//
// Takes one received serial byte per request and returns exactly one result
// per byte: WAIT while a frame is being collected, OK with the sender address,
// distance and raw RSSI when an 8-byte frame closes with a valid head, kind
// byte 0x05 and tail, or LEN/OVF/CONTENT error codes otherwise; the data
// fields read zero for every status but OK. A byte equal to head_value always
// restarts the frame, even when head_value equals tail_value. The block takes
// one byte every clock cycle while the sink keeps taking results; a result is
// offered once its byte has moved through the input register and the
// position/compare logic has loaded the result register. The input register
// doubles as a skid stage, so one more byte is taken while a result waits on
// a stalled sink. Write head_value (index 0) and tail_value (index 1) only
// while no request is in flight.
module ranging_frame_byte_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  rfbp_in_if.sink                         in_ch,
  rfbp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rfbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [rfbp_pkg::BYTE_W-1:0] head_r;
  logic [rfbp_pkg::BYTE_W-1:0] tail_r;

  // Input stage: one byte, also acts as skid when the output stalls.
  logic                        s1_valid_r;
  logic [rfbp_pkg::BYTE_W-1:0] s1_byte_r;

  // Result stage.
  logic                        out_valid_r;
  rfbp_pkg::result_t           out_res_r;

  logic                        in_fire;
  logic                        adv;
  rfbp_pkg::result_t           res;

  // Advance the input stage into the result register when that register is
  // empty or being drained this cycle.
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= rfbp_pkg::HEAD_RESET;
      tail_r <= rfbp_pkg::TAIL_RESET;
    end else if (cfg_we) begin
      unique case (rfbp_pkg::cfg_reg_t'(cfg_index))
        rfbp_pkg::REG_HEAD_VALUE: head_r <= cfg_wdata;
        rfbp_pkg::REG_TAIL_VALUE: tail_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the accepted byte until it moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  rfbp_assembler u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .rx_byte    (s1_byte_r),
    .head_value (head_r),
    .tail_value (tail_r),
    .res        (res)
  );

  // Load a new result, or drop the valid once the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.sender_addr = out_res_r.sender_addr;
  assign out_ch.distance_cm = out_res_r.distance_cm;
  assign out_ch.rssi_raw    = out_res_r.rssi_raw;

  // Data fields stay zero for every status but OK.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != rfbp_pkg::ST_OK) |->
      (out_res_r.sender_addr == '0) && (out_res_r.distance_cm == '0) &&
      (out_res_r.rssi_raw == '0))
    else $error("nonzero data fields on a non-OK result");

  // A byte moving on always lands in the result register.
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("advanced byte produced no result");

  // A stalled result with a full input stage blocks new requests.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("request accepted with both stages full");

endmodule
